// ===== sv/modbus_meter_response_parser_core_macros.svh =====
// Assertion macros for the meter reply parser.
// Included by the top level; needs no package.
`ifndef MODBUS_METER_RESPONSE_PARSER_CORE_MACROS_SVH
`define MODBUS_METER_RESPONSE_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked at every clock edge outside reset.
`define MMRP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked at every clock edge outside reset.
`define MMRP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MMRP_ASSERT_NOW(label, ante, cons)
`define MMRP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/mmrp_pkg.sv =====
// Shared types, constants and the CRC-16/Modbus byte update for the reply parser.
// No dependencies.
`timescale 1ns / 1ps

package mmrp_pkg;

   localparam int unsigned FRAME_LEN  = 25;
   localparam int unsigned STORED_LEN = 22;
   localparam int unsigned INDEX_W    = $clog2(FRAME_LEN);

   localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
   localparam logic [7:0]  DATA_COUNT      = 8'd20;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;

   localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'd1;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_SLAVE_ADDRESS = 2'd0,
      REG_TIMEOUT_TICKS = 2'd1
   } reg_index_type;

   // Input commands.
   typedef enum logic [1:0] {
      CMD_BYTE = 2'd0,
      CMD_ARM  = 2'd1,
      CMD_TICK = 2'd2
   } command_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_CRC_BAD   = 3'd1,
      ST_BAD_FUNC  = 3'd2,
      ST_BAD_COUNT = 3'd3,
      ST_TIMEOUT   = 3'd4,
      ST_BUSY      = 3'd5
   } status_type;

   // One byte through the reflected CRC-16/Modbus: eight shift-and-xor steps.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== sv/mmrp_cell.sv =====
// One byte cell of the frame shift line.
// Depends on mmrp_pkg.
`timescale 1ns / 1ps

module mmrp_cell
   import mmrp_pkg::*;
(
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] byte_in,
   output logic [7:0] byte_out
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_sel;

   // Take the neighbor's byte when the line shifts, else hold.
   assign byte_in_sel = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_sel;
   end

   assign byte_out = byte_ff;

endmodule

// ===== sv/modbus_meter_response_parser_core.sv =====
// Modbus RTU reply parser for an energy meter. The block takes one request word per
// cycle while the output register is free or draining, and delivers its result in the
// next cycle; a new word is taken in the same cycle the waiting result leaves, so the
// rate is one word per cycle, set by the combinational CRC byte update and the 22-cell
// frame shift line. An arm command starts a request; the frame starts at a byte equal
// to slave_address and ends at its 25th byte with one result word. Ticks count toward
// a timeout while armed. Configuration writes are taken at any time and need no wait.
`timescale 1ns / 1ps
`include "modbus_meter_response_parser_core_macros.svh"

module modbus_meter_response_parser_core
   import mmrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_rx_byte,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_voltage,
   output logic [31:0] rsp_current,
   output logic [31:0] rsp_power,
   output logic [31:0] rsp_energy,
   output logic [15:0] rsp_frequency,
   output logic [15:0] rsp_power_factor,
   output logic        rsp_alarm,
   // Configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [7:0]         slave_address_ff;
   logic [15:0]        timeout_ticks_ff;

   logic               armed_ff,       armed_in;
   logic [INDEX_W-1:0] byte_index_ff,  byte_index_in;
   logic [15:0]        running_crc_ff, running_crc_in;
   logic [15:0]        tick_count_ff,  tick_count_in;

   logic               rsp_valid_ff,   rsp_valid_in;
   logic [2:0]         status_ff;
   logic [15:0]        voltage_ff, frequency_ff, power_factor_ff;
   logic [31:0]        current_ff, power_ff, energy_ff;
   logic               alarm_ff;

   logic               req_fire;
   logic               shift_en;
   logic               frame_done;
   logic               result_now;
   status_type         result_status;
   logic [15:0]        crc_next;
   logic [15:0]        tick_next;
   logic [15:0]        tick_limit;
   logic [7:0]         cell_q [STORED_LEN];

   // Configuration is always accepted.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= SLAVE_ADDRESS_RESET;
         timeout_ticks_ff <= TIMEOUT_TICKS_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_SLAVE_ADDRESS) begin
            slave_address_ff <= csr_wdata[7:0];
         end
         if (csr_index == REG_TIMEOUT_TICKS) begin
            timeout_ticks_ff <= csr_wdata;
         end
      end
   end

   // A new word enters when the output register is free or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign crc_next   = crc_byte(running_crc_ff, req_rx_byte);
   assign tick_next  = tick_count_ff + 16'd1;
   assign tick_limit = (timeout_ticks_ff == 16'd0) ? 16'd1 : timeout_ticks_ff;

   // Frame bytes 1 to 22 shift into the cell row; the oldest ends in the last cell.
   assign shift_en = req_fire && (req_command == CMD_BYTE) && armed_ff &&
                     (byte_index_ff != '0) &&
                     (byte_index_ff <= INDEX_W'(STORED_LEN));

   assign frame_done = req_fire && (req_command == CMD_BYTE) && armed_ff &&
                       (byte_index_ff == INDEX_W'(FRAME_LEN - 1));

   for (genvar k = 0; k < STORED_LEN; k++) begin : g_cell
      if (k == 0) begin : g_head
         mmrp_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .byte_in  (req_rx_byte),
            .byte_out (cell_q[k])
         );
      end else begin : g_body
         mmrp_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .byte_in  (cell_q[k-1]),
            .byte_out (cell_q[k])
         );
      end
   end

   // Sequencing of arm, ticks and frame bytes.
   always_comb begin
      armed_in       = armed_ff;
      byte_index_in  = byte_index_ff;
      running_crc_in = running_crc_ff;
      tick_count_in  = tick_count_ff;
      result_now     = 1'b0;
      result_status  = ST_OK;
      if (req_fire) begin
         case (req_command)
            CMD_ARM: begin
               if (armed_ff) begin
                  result_now    = 1'b1;
                  result_status = ST_BUSY;
               end else begin
                  armed_in       = 1'b1;
                  byte_index_in  = '0;
                  running_crc_in = CRC_INIT;
                  tick_count_in  = '0;
               end
            end
            CMD_TICK: begin
               if (armed_ff) begin
                  tick_count_in = tick_next;
                  if (tick_next >= tick_limit) begin
                     armed_in       = 1'b0;
                     byte_index_in  = '0;
                     running_crc_in = CRC_INIT;
                     tick_count_in  = '0;
                     result_now     = 1'b1;
                     result_status  = ST_TIMEOUT;
                  end
               end
            end
            CMD_BYTE: begin
               if (armed_ff) begin
                  if (byte_index_ff == '0) begin
                     if (req_rx_byte == slave_address_ff) begin
                        running_crc_in = crc_byte(CRC_INIT, req_rx_byte);
                        byte_index_in  = INDEX_W'(1);
                     end
                  end else if (frame_done) begin
                     armed_in       = 1'b0;
                     byte_index_in  = '0;
                     running_crc_in = CRC_INIT;
                     tick_count_in  = '0;
                     result_now     = 1'b1;
                     if (crc_next != 16'd0) begin
                        result_status = ST_CRC_BAD;
                     end else if (cell_q[STORED_LEN-1] != FUNC_READ_INPUT) begin
                        result_status = ST_BAD_FUNC;
                     end else if (cell_q[STORED_LEN-2] != DATA_COUNT) begin
                        result_status = ST_BAD_COUNT;
                     end else begin
                        result_status = ST_OK;
                     end
                  end else begin
                     running_crc_in = crc_next;
                     byte_index_in  = byte_index_ff + INDEX_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         byte_index_ff  <= '0;
         running_crc_ff <= CRC_INIT;
         tick_count_ff  <= '0;
      end else begin
         armed_ff       <= armed_in;
         byte_index_ff  <= byte_index_in;
         running_crc_ff <= running_crc_in;
         tick_count_ff  <= tick_count_in;
      end
   end

   // Output register: holds a result word until it is taken.
   assign rsp_valid_in = result_now ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Value fields come from the cell row; 32-bit values carry the low word first.
   always_ff @(posedge clock) begin
      if (result_now) begin
         status_ff <= result_status;
         if (result_status == ST_OK && frame_done) begin
            voltage_ff      <= {cell_q[19], cell_q[18]};
            current_ff      <= {cell_q[15], cell_q[14], cell_q[17], cell_q[16]};
            power_ff        <= {cell_q[11], cell_q[10], cell_q[13], cell_q[12]};
            energy_ff       <= {cell_q[7], cell_q[6], cell_q[9], cell_q[8]};
            frequency_ff    <= {cell_q[5], cell_q[4]};
            power_factor_ff <= {cell_q[3], cell_q[2]};
            alarm_ff        <= (cell_q[1] != 8'd0) || (cell_q[0] != 8'd0);
         end else begin
            voltage_ff      <= '0;
            current_ff      <= '0;
            power_ff        <= '0;
            energy_ff       <= '0;
            frequency_ff    <= '0;
            power_factor_ff <= '0;
            alarm_ff        <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_voltage      = voltage_ff;
   assign rsp_current      = current_ff;
   assign rsp_power        = power_ff;
   assign rsp_energy       = energy_ff;
   assign rsp_frequency    = frequency_ff;
   assign rsp_power_factor = power_factor_ff;
   assign rsp_alarm        = alarm_ff;

   // Checks on the sequencing.
   `MMRP_ASSERT_NOW(a_index_range, 1'b1, byte_index_ff <= INDEX_W'(FRAME_LEN - 1))
   `MMRP_ASSERT_NOW(a_idle_clear, !armed_ff, byte_index_ff == '0 && tick_count_ff == '0)
   `MMRP_ASSERT_NOW(a_crc_at_sync, byte_index_ff == '0, running_crc_ff == CRC_INIT)
   `MMRP_ASSERT_NEXT(a_frame_result, frame_done, rsp_valid_ff && !armed_ff)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the meter reply parser core: a directed table, then random
// phases of reply frames, noise and ticks, all checked against an in-bench predictor.
// Depends on mmrp_pkg and modbus_meter_response_parser_core.
`timescale 1ns / 1ps

module tb;
   import mmrp_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned PHASE_COUNT   = 10;
   localparam int unsigned PHASE_WORDS   = 130;
   localparam logic [1:0]  CMD_UNUSED    = 2'd3;

   // One parsed meter reading as it leaves the result channel.
   typedef struct packed {
      status_type  status;
      logic [15:0] voltage;
      logic [31:0] current;
      logic [31:0] power;
      logic [31:0] energy;
      logic [15:0] frequency;
      logic [15:0] power_factor;
      logic        alarm;
   } meter_reading_t;

   typedef enum logic [0:0] {ROW_WORD, ROW_CSR} row_kind_t;
   typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_STATUS} row_check_t;

   // One line of the directed plan: a request word or a register write.
   typedef struct packed {
      row_kind_t     kind;
      logic [1:0]    cmd;
      logic [7:0]    rx;
      reg_index_type idx;
      logic [15:0]   wdata;
      row_check_t    check;
      status_type    status;
   } plan_row_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_voltage;
   logic [31:0] rsp_current;
   logic [31:0] rsp_power;
   logic [31:0] rsp_energy;
   logic [15:0] rsp_frequency;
   logic [15:0] rsp_power_factor;
   logic        rsp_alarm;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_SLAVE_ADDRESS;
   logic [15:0] csr_wdata = 16'h0000;

   // Predictor state and its copy of the registers.
   logic        meter_armed = 1'b0;
   logic [4:0]  frame_pos = '0;
   logic [15:0] frame_crc = CRC_INIT;
   logic [7:0]  frame_buf [STORED_LEN];
   logic [15:0] tick_total = '0;
   logic [7:0]  cfg_slave = SLAVE_ADDRESS_RESET;
   logic [15:0] cfg_ticks = TIMEOUT_TICKS_RESET;

   meter_reading_t pending_readings [$];
   int unsigned    mismatches = 0;
   int unsigned    words_sent = 0;
   int unsigned    cycle_count = 0;
   int unsigned    tick_pct = 10;
   bit             calm = 1'b0;

   // Directed plan: idle handling, busy, timeouts, sync and address changes.
   plan_row_t plan [22] = '{
      '{ROW_WORD, CMD_BYTE,   8'h00, REG_SLAVE_ADDRESS, 16'h0000, EXP_NONE,   ST_OK},
      '{ROW_WORD, CMD_BYTE,   8'hFF, REG_SLAVE_ADDRESS, 16'h0000, EXP_NONE,   ST_OK},
      '{ROW_WORD, CMD_TICK,   8'h00, REG_SLAVE_ADDRESS, 16'h0000, EXP_NONE,   ST_OK},
      '{ROW_WORD, CMD_UNUSED, 8'hA5, REG_SLAVE_ADDRESS, 16'h0000, EXP_NONE,   ST_OK},
      '{ROW_WORD, CMD_ARM,    8'h00, REG_SLAVE_ADDRESS, 16'h0000, EXP_NONE,   ST_OK},
      '{ROW_WORD, CMD_ARM,    8'hFF, REG_SLAVE_ADDRESS, 16'h0000, EXP_STATUS, ST_BUSY},
      '{ROW_WORD, CMD_BYTE,   8'h02, REG_SLAVE_ADDRESS, 16'h0000, EXP_MODEL,  ST_OK},
      '{ROW_WORD, CMD_UNUSED, 8'h5A, REG_SLAVE_ADDRESS, 16'h0000, EXP_MODEL,  ST_OK},
      '{ROW_WORD, CMD_BYTE,   8'h01, REG_SLAVE_ADDRESS, 16'h0000, EXP_MODEL,  ST_OK},
      '{ROW_CSR,  CMD_BYTE,   8'h00, REG_TIMEOUT_TICKS, 16'd2,    EXP_NONE,   ST_OK},
      '{ROW_WORD, CMD_TICK,   8'h00, REG_SLAVE_ADDRESS, 16'h0000, EXP_MODEL,  ST_OK},
      '{ROW_WORD, CMD_TICK,   8'h00, REG_SLAVE_ADDRESS, 16'h0000, EXP_STATUS, ST_TIMEOUT},
      '{ROW_CSR,  CMD_BYTE,   8'h00, REG_TIMEOUT_TICKS, 16'd0,    EXP_NONE,   ST_OK},
      '{ROW_WORD, CMD_ARM,    8'h00, REG_SLAVE_ADDRESS, 16'h0000, EXP_NONE,   ST_OK},
      '{ROW_WORD, CMD_TICK,   8'h00, REG_SLAVE_ADDRESS, 16'h0000, EXP_STATUS, ST_TIMEOUT},
      '{ROW_CSR,  CMD_BYTE,   8'h00, REG_SLAVE_ADDRESS, 16'd248,  EXP_NONE,   ST_OK},
      '{ROW_WORD, CMD_ARM,    8'h00, REG_SLAVE_ADDRESS, 16'h0000, EXP_MODEL,  ST_OK},
      '{ROW_WORD, CMD_BYTE,   8'h01, REG_SLAVE_ADDRESS, 16'h0000, EXP_MODEL,  ST_OK},
      '{ROW_WORD, CMD_BYTE,   8'hF8, REG_SLAVE_ADDRESS, 16'h0000, EXP_MODEL,  ST_OK},
      '{ROW_WORD, CMD_ARM,    8'h00, REG_SLAVE_ADDRESS, 16'h0000, EXP_STATUS, ST_BUSY},
      '{ROW_CSR,  CMD_BYTE,   8'h00, REG_SLAVE_ADDRESS, 16'd1,    EXP_NONE,   ST_OK},
      '{ROW_CSR,  CMD_BYTE,   8'h00, REG_TIMEOUT_TICKS, 16'hFFFF, EXP_NONE,   ST_OK}
   };

   modbus_meter_response_parser_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_voltage      (rsp_voltage),
      .rsp_current      (rsp_current),
      .rsp_power        (rsp_power),
      .rsp_energy       (rsp_energy),
      .rsp_frequency    (rsp_frequency),
      .rsp_power_factor (rsp_power_factor),
      .rsp_alarm        (rsp_alarm),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Free-running 2 ns clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // CRC-16/Modbus over one byte, taken one bit at a time, LSB first.
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
      logic fb;
      for (int k = 0; k < 8; k++) begin
         fb  = acc[0] ^ b[k];
         acc = acc >> 1;
         if (fb) acc = acc ^ CRC_POLY;
      end
      return acc;
   endfunction

   // Drops the pending request and restarts frame collection.
   function automatic void drop_request();
      meter_armed = 1'b0;
      frame_pos   = '0;
      frame_crc   = CRC_INIT;
      tick_total  = '0;
   endfunction

   // Advances the predicted parser by one request word; returns 1 when a reading results.
   function automatic logic predict_word(input logic [1:0] cmd, input logic [7:0] rx,
                                         output meter_reading_t res);
      logic [15:0] limit;
      logic [15:0] residue;
      res = '0;
      case (cmd)
         CMD_ARM: begin
            if (meter_armed) begin
               res.status = ST_BUSY;
               return 1'b1;
            end
            drop_request();
            meter_armed = 1'b1;
            return 1'b0;
         end
         CMD_TICK: begin
            if (!meter_armed) return 1'b0;
            limit      = (cfg_ticks == 16'd0) ? 16'd1 : cfg_ticks;
            tick_total = tick_total + 16'd1;
            if (tick_total >= limit) begin
               drop_request();
               res.status = ST_TIMEOUT;
               return 1'b1;
            end
            return 1'b0;
         end
         CMD_BYTE: begin
            if (!meter_armed) return 1'b0;
            // Hunt for the slave address before a frame starts.
            if (frame_pos == 0) begin
               if (rx != cfg_slave) return 1'b0;
               frame_crc = crc16_step(CRC_INIT, rx);
               frame_pos = 5'd1;
               return 1'b0;
            end
            if (frame_pos <= STORED_LEN) frame_buf[frame_pos - 1] = rx;
            frame_crc = crc16_step(frame_crc, rx);
            frame_pos = frame_pos + 5'd1;
            if (frame_pos < FRAME_LEN) return 1'b0;
            // Frame complete: CRC, then function code, then byte count.
            residue = frame_crc;
            drop_request();
            if (residue != 16'h0000) res.status = ST_CRC_BAD;
            else if (frame_buf[0] != FUNC_READ_INPUT) res.status = ST_BAD_FUNC;
            else if (frame_buf[1] != DATA_COUNT) res.status = ST_BAD_COUNT;
            else begin
               // 32-bit values arrive low register first, each register big endian.
               res.voltage      = {frame_buf[2], frame_buf[3]};
               res.current      = {frame_buf[6], frame_buf[7], frame_buf[4], frame_buf[5]};
               res.power        = {frame_buf[10], frame_buf[11], frame_buf[8], frame_buf[9]};
               res.energy       = {frame_buf[14], frame_buf[15], frame_buf[12], frame_buf[13]};
               res.frequency    = {frame_buf[16], frame_buf[17]};
               res.power_factor = {frame_buf[18], frame_buf[19]};
               res.alarm        = |{frame_buf[20], frame_buf[21]};
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Idle length: mostly none, some short, a few long; none during calm stretches.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 99) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Presents one request word after a random gap and holds it until accepted.
   task automatic drive_word(input logic [1:0] cmd, input logic [7:0] rx);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_command = cmd;
      req_rx_byte = rx;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Predicts and sends one request word.
   task automatic send_word(input logic [1:0] cmd, input logic [7:0] rx);
      meter_reading_t res;
      if (predict_word(cmd, rx, res)) pending_readings.push_back(res);
      drive_word(cmd, rx);
   endtask

   // Stops sending and waits until every expected reading has come out.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, issued only once the parser has gone quiet.
   task automatic write_reg(input reg_index_type idx, input logic [15:0] value);
      drain_results();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_SLAVE_ADDRESS) cfg_slave = value[7:0];
      else cfg_ticks = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Builds one reply frame, mostly well formed, with ticks and stray arms mixed in.
   task automatic send_frame();
      logic [7:0]  fr [FRAME_LEN];
      logic [15:0] crc;
      logic [7:0]  b;
      int unsigned fill;
      int unsigned spot;
      fr[0] = cfg_slave;
      fr[1] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : FUNC_READ_INPUT;
      fr[2] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : DATA_COUNT;
      fill  = $urandom_range(0, 9);
      for (int i = 3; i < 23; i++) begin
         fr[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
      end
      if ($urandom_range(0, 1) == 0) begin
         fr[21] = 8'h00;
         fr[22] = 8'h00;
      end
      crc = CRC_INIT;
      for (int i = 0; i < 23; i++) crc = crc16_step(crc, fr[i]);
      fr[23] = crc[7:0];
      fr[24] = crc[15:8];
      // Now and then damage one byte after the address.
      if ($urandom_range(0, 9) == 0) begin
         spot     = $urandom_range(1, 24);
         fr[spot] = fr[spot] ^ 8'($urandom_range(1, 255));
      end
      if (!meter_armed || $urandom_range(0, 9) == 0) send_word(CMD_ARM, 8'($urandom));
      repeat ($urandom_range(0, 3)) begin
         b = 8'($urandom);
         if (b == cfg_slave) b = ~b;
         send_word(CMD_BYTE, b);
      end
      for (int i = 0; i < FRAME_LEN; i++) begin
         if ($urandom_range(0, 99) < tick_pct) send_word(CMD_TICK, 8'($urandom));
         if ($urandom_range(0, 199) == 0) send_word(CMD_ARM, 8'($urandom));
         send_word(CMD_BYTE, fr[i]);
      end
   endtask

   // Random stalls on the result side.
   initial begin
      int unsigned stall;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 99) < 25) begin
            stall = pick_gap();
            if (stall != 0) begin
               rsp_ready = 1'b0;
               repeat (stall) @(negedge clock);
               rsp_ready = 1'b1;
            end
         end
      end
   end

   // Compares one field of a reading and logs any difference.
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Result checker: each accepted reading against the oldest expectation.
   always @(posedge clock) begin
      meter_reading_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected reading, expected none, got status %0d",
                     $time, rsp_status);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("voltage", 32'(want.voltage), 32'(rsp_voltage));
            check_field("current", want.current, rsp_current);
            check_field("power", want.power, rsp_power);
            check_field("energy", want.energy, rsp_energy);
            check_field("frequency", 32'(want.frequency), 32'(rsp_frequency));
            check_field("power_factor", 32'(want.power_factor), 32'(rsp_power_factor));
            check_field("alarm", 32'(want.alarm), 32'(rsp_alarm));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("[modbus_meter_response_parser_core] ERROR");
         $finish;
      end
   end

   // Main sequence: reset, directed plan, random phases, final drain.
   initial begin
      meter_reading_t res;
      meter_reading_t typed;
      logic           hit;
      logic [7:0]     addr;
      logic [15:0]    ticks;
      int unsigned    phase_end;
      int unsigned    r;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed plan.
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            write_reg(plan[i].idx, plan[i].wdata);
         end else begin
            hit = predict_word(plan[i].cmd, plan[i].rx, res);
            case (plan[i].check)
               EXP_MODEL: if (hit) pending_readings.push_back(res);
               EXP_STATUS: begin
                  typed        = '0;
                  typed.status = plan[i].status;
                  pending_readings.push_back(typed);
               end
               default: ;
            endcase
            drive_word(plan[i].cmd, plan[i].rx);
         end
      end

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase != 0) begin
            case (phase)
               1: begin
                  addr  = 8'd248;
                  ticks = TIMEOUT_TICKS_RESET;
               end
               2: begin
                  addr  = 8'($urandom_range(2, 247));
                  ticks = 16'd1;
               end
               3: begin
                  addr  = 8'd1;
                  ticks = 16'($urandom_range(2, 12));
               end
               4: begin
                  addr  = 8'($urandom_range(1, 248));
                  ticks = 16'($urandom_range(13, 400));
               end
               default: begin
                  addr  = 8'($urandom_range(1, 248));
                  ticks = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(2, 40)) : 16'hFFFF;
               end
            endcase
            write_reg(REG_SLAVE_ADDRESS, {8'h00, addr});
            write_reg(REG_TIMEOUT_TICKS, ticks);
         end
         calm      = (phase % 4 == 3);
         tick_pct  = (cfg_ticks <= 16'd12) ? 4 : 20;
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 70) send_frame();
            else if (r < 85) send_word(2'($urandom), 8'($urandom));
            else if (r < 97) repeat ($urandom_range(1, 16)) send_word(CMD_TICK, 8'($urandom));
            else drain_results();
         end
      end

      calm = 1'b0;
      drain_results();
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("[modbus_meter_response_parser_core] OK");
      end else begin
         $display("[modbus_meter_response_parser_core] ERROR");
      end
      $finish;
   end

endmodule
